[rtl/lru_pkg.sv]
// Shared types and sizing constants for the LRU page replacement block.
// Used by lru_ctrl, lru_dp and the top level lru_page_replacement.
package lru_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;
  localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int CFG_W     = 4;
  localparam int FAULT_W   = 32;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [FRAME_W-1:0]   frame_t;
  typedef logic [CNT_W-1:0]     count_t;
  typedef logic [FRAME_W-1:0]   rank_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // latch request, restart scan
    logic step;    // compare one frame
    logic commit;  // update state, load result register
  } lru_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic match;      // current frame holds the page
    logic last;       // current frame is the last filled one
    logic empty;      // no frame filled yet
    logic out_busy;   // result register still held
  } lru_stat_t;

endpackage

[rtl/lru_page_replacement.sv]
// Top level of the LRU page replacement block.
// Depends on lru_pkg, lru_ctrl and lru_dp.
//
// One request carries a page number and yields one result: hit or miss, the
// frame that holds the page afterwards, the evicted page if a resident page
// was replaced, and a saturating page-fault total. A request is taken only
// while the block is idle. It then accepts the request, steps through the
// filled frames in a sequential scan (stopping early at the first matching
// frame, lowest index first), and finally updates its state. The result sits
// in an output register, and the update step waits only while that register
// still holds an untaken result. On a miss, free frames are filled in index
// order while fewer than frames_in_use are filled (0 counts as 1, values
// above FRAMES as FRAMES); after that the frame with the oldest recency rank,
// lowest index on a tie, is replaced. Write frames_in_use only while idle and
// reset after changing it.
module lru_page_replacement
  import lru_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  page_t              page_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output frame_t             frame_index,
  output logic               evicted_valid,
  output page_t              evicted_page,
  output logic [FAULT_W-1:0] fault_total
);

  lru_cmd_t  cmd;
  lru_stat_t stat;

  // Sequence each request: accept, scan, update
  lru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold frames, ranks and counters; build the result
  lru_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .page_number   (page_number),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
  );

endmodule

[rtl/lru_ctrl.sv]
// Controller state machine for the LRU page replacement block.
// Depends on lru_pkg; drives lru_dp through lru_cmd_t.
module lru_ctrl
  import lru_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  lru_stat_t stat,
  output lru_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.empty ? S_UPD : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (stat.match || stat.last) state_next = S_UPD;
      end
      S_UPD: begin
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

[rtl/lru_dp.sv]
// Datapath of the LRU page replacement block: frame table, recency ranks,
// scan registers, fault counter and result register. Depends on lru_pkg.
module lru_dp
  import lru_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  page_t                page_number,
  input  lru_cmd_t             cmd,
  output lru_stat_t            stat,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 hit,
  output frame_t               frame_index,
  output logic                 evicted_valid,
  output page_t                evicted_page,
  output logic [FAULT_W-1:0]   fault_total
);

  page_t              frame_page [FRAMES];
  rank_t              rank       [FRAMES];
  count_t             filled;
  logic [FAULT_W-1:0] faults;
  logic [CFG_W-1:0]   frames_in_use;

  page_t  page_reg;
  frame_t idx;
  logic   found;
  frame_t hit_idx;
  frame_t best_idx;
  rank_t  best_rank;
  page_t  best_page;

  page_t  cur_page;
  rank_t  cur_rank;
  count_t active;
  logic   fill;
  frame_t f;
  rank_t  f_rank;
  logic [FAULT_W-1:0] faults_next;

  assign cur_page = frame_page[idx];
  assign cur_rank = rank[idx];

  assign stat.match    = (cur_page == page_reg);
  assign stat.last     = ((CNT_W'(idx) + CNT_W'(1)) == filled);
  assign stat.empty    = (filled == '0);
  assign stat.out_busy = out_valid && !out_ready;

  // Clamp the configured frame count to 1..FRAMES
  always_comb begin
    if (frames_in_use == '0)                 active = CNT_W'(1);
    else if (32'(frames_in_use) > FRAMES)    active = CNT_W'(FRAMES);
    else                                     active = CNT_W'(frames_in_use);
  end

  always_comb begin
    fill = !found && (filled < active);
    if (found)     f = hit_idx;
    else if (fill) f = filled[FRAME_W-1:0];
    else           f = best_idx;
    f_rank      = rank[f];
    faults_next = (faults == '1) ? faults : faults + FAULT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) frames_in_use <= CFG_W'(8);
    else if (cfg_wr_en) frames_in_use <= cfg_wr_data;
  end

  // Scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_reg <= page_number;
      idx      <= '0;
      found    <= 1'b0;
    end else if (cmd.step) begin
      if (stat.match) begin
        found   <= 1'b1;
        hit_idx <= idx;
      end
      if (idx == '0 || cur_rank > best_rank) begin
        best_rank <= cur_rank;
        best_idx  <= idx;
        best_page <= cur_page;
      end
      idx <= idx + FRAME_W'(1);
    end
  end

  // Frame table: written only on a miss
  always_ff @(posedge clk) begin
    if (cmd.commit && !found) frame_page[f] <= page_reg;
  end

  // Recency ranks, fill count and fault counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRAMES; i++) rank[i] <= '0;
      filled <= '0;
      faults <= '0;
    end else if (cmd.commit) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (FRAME_W'(i) == f) begin
          rank[i] <= '0;
        end else if (CNT_W'(i) < filled) begin
          if (fill) begin
            if (rank[i] != '1) rank[i] <= rank[i] + FRAME_W'(1);
          end else if (rank[i] < f_rank) begin
            rank[i] <= rank[i] + FRAME_W'(1);
          end
        end
      end
      if (fill)   filled <= filled + CNT_W'(1);
      if (!found) faults <= faults_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit           <= found;
      frame_index   <= f;
      evicted_valid <= !found && !fill;
      evicted_page  <= (!found && !fill) ? best_page : '0;
      fault_total   <= found ? faults : faults_next;
    end
  end

endmodule
